// ===== rtl/isort_pkg.sv =====
// shared types and constants of the insertion sorter
package isort_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 16;

	// what one cell shows its neighbours
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     valid;
		logic                     shift;
		logic                     run;
	} isort_link_t;

	// control and data sent to every cell
	typedef struct packed {
		logic                     insert;
		logic                     pop;
		logic                     descending;
		logic signed [DATA_W-1:0] value;
	} isort_bcast_t;

endpackage

// ===== rtl/isort_cell.sv =====
// one slot of the sorting chain
module isort_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  isort_pkg::isort_bcast_t bcast,
	input  isort_pkg::isort_link_t  from_left,
	input  isort_pkg::isort_link_t  from_right,
	output isort_pkg::isort_link_t  link
);
	import isort_pkg::*;

	logic signed [DATA_W-1:0] value_q;
	logic                     valid_q;
	logic                     precede;
	logic                     run;
	logic                     shift;
	logic                     take;

	// new value must precede the held one
	assign precede = bcast.descending ? (bcast.value > value_q) : (bcast.value < value_q);
	// run of entries, reaching the tail, that all move aside
	assign run    = valid_q ? (precede && from_right.run) : 1'b1;
	assign shift  = valid_q && run;
	// load on a move, or as the first free slot
	assign take   = bcast.insert && (shift || (!valid_q && from_left.valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bcast.pop) begin
			valid_q <= from_right.valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (bcast.pop) begin
			value_q <= from_right.value;
		end else if (take) begin
			value_q <= from_left.shift ? from_left.value : bcast.value;
		end
	end

	assign link.value = value_q;
	assign link.valid = valid_q;
	assign link.shift = shift;
	assign link.run   = run;

endmodule

// ===== rtl/insertion_sorter.sv =====
// top level of the streaming insertion sorter
//
// input channel: in_valid/in_ready with value and last. each beat is
// placed into a chain of CAPACITY cells in the cycle it is accepted, so a
// set streams in at one beat per cycle. a beat that finds the chain full is
// dropped and the set is flagged.
// the beat with last set closes the set. from the next cycle the chain
// drains through out_valid/out_ready, head cell first, one beat per cycle
// while the receiver takes them; last_res marks the final one and overflow
// carries the drop flag on every beat of the set.
// the first result is offered in the cycle after the closing beat. the
// chain shifts toward its head one place per pop; in_ready is low during
// the drain. a stalled receiver simply holds the chain, nothing is lost.
// reset empties the chain (valid bits only), clears the drop flag and
// selects ascending order. cfg_wr_en/cfg_wr_data write the direction bit
// and may only be used between sets.
module insertion_sorter #(
	parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic                              cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [isort_pkg::DATA_W-1:0] value,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [isort_pkg::DATA_W-1:0] value_res,
	output logic                              last_res,
	output logic                              overflow
);
	import isort_pkg::*;

	logic         descending_q;
	logic         drain_q;
	logic         dropped_q;
	logic         in_acc;
	logic         full;
	logic         pop;
	isort_bcast_t bcast;
	isort_link_t  link [CAPACITY];
	isort_link_t  head_link;
	isort_link_t  tail_link;

	// direction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q <= 1'b0;
		end else if (cfg_wr_en) begin
			descending_q <= cfg_wr_data;
		end
	end

	assign in_ready = !drain_q;
	assign in_acc   = in_valid && in_ready;
	// the tail cell holding data means no room left
	assign full     = link[CAPACITY-1].valid;

	assign out_valid = drain_q && link[0].valid;
	assign pop       = out_valid && out_ready;
	// head is the final one when the next cell is already empty
	assign last_res  = !link[1].valid;
	assign value_res = link[0].value;
	assign overflow  = dropped_q;

	assign bcast.insert     = in_acc && !full;
	assign bcast.pop        = pop;
	assign bcast.descending = descending_q;
	assign bcast.value      = value;

	// boundary: left of the head acts as a held, unmoved entry
	assign head_link.value = '0;
	assign head_link.valid = 1'b1;
	assign head_link.shift = 1'b0;
	assign head_link.run   = 1'b0;
	// boundary: right of the tail acts as empty
	assign tail_link.value = '0;
	assign tail_link.valid = 1'b0;
	assign tail_link.shift = 1'b0;
	assign tail_link.run   = 1'b1;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		isort_link_t left_l;
		isort_link_t right_l;
		if (i == 0) begin : g_head
			assign left_l = head_link;
		end else begin : g_mid_l
			assign left_l = link[i-1];
		end
		if (i == CAPACITY-1) begin : g_tail
			assign right_l = tail_link;
		end else begin : g_mid_r
			assign right_l = link[i+1];
		end
		isort_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.bcast      (bcast),
			.from_left  (left_l),
			.from_right (right_l),
			.link       (link[i])
		);
	end

	// set control: gather, then drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q   <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			if (in_acc && full) begin
				dropped_q <= 1'b1;
			end
			if (in_acc && last) begin
				drain_q <= 1'b1;
			end
			if (pop && last_res) begin
				drain_q   <= 1'b0;
				dropped_q <= 1'b0;
			end
		end
	end

	// the head holds data for the whole drain
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> link[0].valid)
		else $error("drain with empty head cell");

	// an insertion always leaves the head filled
	a_insert_head: assert property (@(posedge clk) disable iff (!arst_n)
		bcast.insert |=> link[0].valid)
		else $error("insertion left head cell empty");

	// a pop that is not the final one keeps results coming
	a_drain_go_on: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !last_res) |=> out_valid)
		else $error("drain stopped early");

	// a beat refused for lack of room raises the flag
	a_drop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && full) |=> overflow)
		else $error("drop not flagged");

endmodule

// ===== sim/insertion_sorter_tb.sv =====
// self-checking testbench of the streaming insertion sorter
module insertion_sorter_tb;
	import isort_pkg::*;

	localparam int CAP       = CAPACITY_DEF;
	localparam int N_ITEMS   = 170;     // input beats, directed and random together
	localparam int SETTLE    = 4;       // quiet cycles before touching the direction bit
	localparam int HOLD_OFF  = 200;     // one long receiver stall to back the chain up
	localparam int TAIL      = 8;       // cycles watched after the last result
	localparam int MAX_SHOWN = 40;      // mismatch lines printed, the rest only counted
	localparam int N_ROWS    = 22;

	localparam logic signed [DATA_W-1:0] V_MIN  = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] V_MAX  = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] V_ZERO = 32'sh0000_0000;
	localparam logic signed [DATA_W-1:0] V_NEG1 = 32'shffff_ffff;

	localparam logic DIR_ASC  = 1'b0;
	localparam logic DIR_DESC = 1'b1;

	typedef enum int {RX_OPEN, RX_PATTERN, RX_COIN} rx_mode_t;
	typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE} val_style_t;

	// one sorted beat as it should leave the block
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} sorted_beat_t;

	// one directed beat; lone marks a single-value set sent into an empty chain
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     set_dir;
		logic                     dir;
		logic                     lone;
	} stim_row_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     cfg_wr_en   = 1'b0;
	logic                     cfg_wr_data = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] value       = '0;
	logic                     last        = 1'b0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DATA_W-1:0] value_res;
	logic                     last_res;
	logic                     overflow;

	// predictor state: chain contents in order, drop flag, direction
	logic signed [DATA_W-1:0] held [$];
	logic                     held_dropped = 1'b0;
	logic                     sort_desc    = 1'b0;
	sorted_beat_t             due_beats [$];

	bit hold_off_req = 1'b0;
	int burst_left   = 0;
	int n_errors     = 0;
	int n_beats      = 0;
	int n_results    = 0;
	int n_sets       = 0;
	int n_ovf_sets   = 0;
	int n_dir_writes = 0;

	stim_row_t dir_rows [N_ROWS] = '{
		// lone values straight after reset: the extremes come back unchanged
		'{V_MIN,          1'b1, 1'b1, DIR_ASC,  1'b1},
		'{V_MAX,          1'b1, 1'b0, DIR_ASC,  1'b1},
		'{V_ZERO,         1'b1, 1'b0, DIR_ASC,  1'b1},
		'{V_NEG1,         1'b1, 1'b0, DIR_ASC,  1'b1},
		// ascending set with both extremes and a repeated value
		'{32'sd5,         1'b0, 1'b0, DIR_ASC,  1'b0},
		'{V_MAX,          1'b0, 1'b0, DIR_ASC,  1'b0},
		'{-32'sd7,        1'b0, 1'b0, DIR_ASC,  1'b0},
		'{V_MIN,          1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd5,         1'b0, 1'b0, DIR_ASC,  1'b0},
		'{V_ZERO,         1'b1, 1'b0, DIR_ASC,  1'b0},
		// descending set, again with equals
		'{32'sd3,         1'b0, 1'b1, DIR_DESC, 1'b0},
		'{V_MIN,          1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd3,         1'b0, 1'b0, DIR_ASC,  1'b0},
		'{V_MAX,          1'b0, 1'b0, DIR_ASC,  1'b0},
		'{V_NEG1,         1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd1,         1'b1, 1'b0, DIR_ASC,  1'b0},
		'{32'sh1234_5678, 1'b1, 1'b0, DIR_ASC,  1'b1},
		// direction flipped part way through a set, earlier entries stay put
		'{32'sd10,        1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd20,        1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd15,        1'b0, 1'b1, DIR_ASC,  1'b0},
		'{-32'sd5,        1'b0, 1'b0, DIR_ASC,  1'b0},
		'{32'sd25,        1'b1, 1'b0, DIR_ASC,  1'b0}
	};

	insertion_sorter #(
		.CAPACITY    (CAP)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.last        (last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value_res   (value_res),
		.last_res    (last_res),
		.overflow    (overflow)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		if (n_errors < MAX_SHOWN)
			$display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
		n_errors++;
	endtask

	// insert one accepted beat into the predicted chain; a closing beat
	// turns the chain into expected results and empties it
	function automatic void insert_and_close(input logic signed [DATA_W-1:0] v,
			input logic l);
		int pos;
		if (held.size() >= CAP) begin
			held_dropped = 1'b1;
		end else begin
			pos = held.size();
			// equals stay ahead of the newcomer
			while (pos > 0 && (sort_desc ? (v > held[pos-1]) : (v < held[pos-1])))
				pos--;
			held.insert(pos, v);
		end
		if (l) begin
			foreach (held[k])
				due_beats.push_back('{held[k], k == held.size() - 1, held_dropped});
			n_sets++;
			if (held_dropped)
				n_ovf_sets++;
			held.delete();
			held_dropped = 1'b0;
		end
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value(input val_style_t style);
		case (style)
		VAL_WIDE: begin
			return $urandom;
		end
		VAL_NARROW: begin
			// tight range, so equal values are common
			return $signed($urandom_range(0, 6)) - 3;
		end
		default: begin
			case ($urandom_range(0, 5))
			0: return V_MIN;
			1: return V_MAX;
			2: return V_ZERO;
			3: return V_NEG1;
			4: return 32'sd1;
			default: return $urandom;
			endcase
		end
		endcase
	endfunction

	// offer one beat and hold it until the block takes it
	task automatic send_beat(input logic signed [DATA_W-1:0] v, input logic l);
		in_valid <= 1'b1;
		value    <= v;
		last     <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_beats++;
	endtask

	// bursts of random length, random gaps between them
	task automatic pace_sender();
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	// stop offering until every due result is out and the chain is quiet
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (due_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_direction(input logic d);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= d;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		sort_desc    = d;
		n_dir_writes++;
	endtask

	// offer a random beat and fold it into the prediction once taken
	task automatic value_last_send(input logic signed [DATA_W-1:0] v, input logic l);
		send_beat(v, l);
		insert_and_close(v, l);
	endtask

	// compare every result beat with the oldest one due
	always @(posedge clk) begin : result_check
		sorted_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			n_results++;
			if (due_beats.size() == 0) begin
				report_mismatch("beat with nothing due, value_res", value_res, '0);
			end else begin
				want = due_beats.pop_front();
				if (value_res !== want.value)
					report_mismatch("value_res", value_res, want.value);
				if (last_res !== want.last)
					report_mismatch("last_res", DATA_W'(last_res), DATA_W'(want.last));
				if (overflow !== want.ovf)
					report_mismatch("overflow", DATA_W'(overflow), DATA_W'(want.ovf));
			end
		end
	end

	// receiver: phases of open, patterned and coin-flip readiness, plus one
	// long hold-off on request
	initial begin : receiver
		rx_mode_t    mode;
		int          span;
		logic [15:0] pat;
		pat = 16'b1101_0011_1000_1110;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
				hold_off_req = 1'b0;
			end
			mode = rx_mode_t'($urandom_range(0, 2));
			span = $urandom_range(4, 40);
			repeat (span) begin
				if (hold_off_req)
					break;
				case (mode)
				RX_OPEN: begin
					out_ready <= 1'b1;
				end
				RX_PATTERN: begin
					out_ready <= pat[0];
					pat = {pat[0], pat[15:1]};
				end
				default: begin
					out_ready <= 1'($urandom_range(0, 1));
				end
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : sender
		int         set_no;
		int         set_len;
		int         pick;
		int         i;
		int         tail_wait;
		val_style_t style;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows; lone rows have their result written straight in
		foreach (dir_rows[r]) begin
			if (dir_rows[r].set_dir) begin
				wait_drained();
				set_direction(dir_rows[r].dir);
			end
			pace_sender();
			send_beat(dir_rows[r].value, dir_rows[r].last);
			if (dir_rows[r].lone) begin
				due_beats.push_back('{dir_rows[r].value, 1'b1, 1'b0});
				n_sets++;
			end else begin
				insert_and_close(dir_rows[r].value, dir_rows[r].last);
			end
		end

		// random sets; the receiver sits on the first full set so the
		// sender runs into a stalled input
		hold_off_req = 1'b1;
		set_no       = 0;
		while (n_beats < N_ITEMS) begin
			if (set_no == 0) begin
				set_len = CAP;
			end else if (set_no == 1) begin
				set_len = CAP + 4;          // closing beat arrives on a full chain
			end else begin
				pick = $urandom_range(0, 9);
				if (pick == 0)
					set_len = $urandom_range(CAP + 1, CAP + 6);
				else if (pick == 1)
					set_len = CAP;
				else
					set_len = $urandom_range(1, 12);
			end
			style = val_style_t'($urandom_range(0, 2));
			pick  = $urandom_range(0, 5);
			if (pick <= 1) begin
				wait_drained();
				set_direction(1'($urandom_range(0, 1)));
			end else if (pick == 2) begin
				wait_drained();
			end
			for (i = 0; i < set_len; i++) begin
				// now and then flip the direction inside a set
				if (i > 0 && $urandom_range(0, 15) == 0) begin
					wait_drained();
					set_direction(~sort_desc);
				end
				pace_sender();
				value_last_send(pick_value(style), i == set_len - 1);
			end
			set_no++;
		end

		in_valid  <= 1'b0;
		tail_wait  = 0;
		while (due_beats.size() != 0 && tail_wait < 20000) begin
			@(posedge clk);
			tail_wait++;
		end
		repeat (TAIL) @(posedge clk);
		if (due_beats.size() != 0)
			report_mismatch("results still due at the end, count", due_beats.size(), 0);

		$display("run: %0d beats in, %0d sets (%0d with drops), %0d sorted beats out",
			n_beats, n_sets, n_ovf_sets, n_results);
		$display("run: %0d direction writes, %0d mismatches", n_dir_writes, n_errors);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
